>>> rtl/pag_pkg.sv
// ----------------------------------------------------------------------------
// pag_pkg: shared types and constants for the Pareto archive grid update unit
// Holds archive sizing, grid constants, the verdict codes and the controller
// states.
// ----------------------------------------------------------------------------
package pag_pkg;

  localparam int ArchiveSize = 64;
  localparam int GridDepth   = 4;
  localparam int AddrW       = $clog2(ArchiveSize);
  localparam int CountW      = AddrW + 1;
  localparam int CellW       = 2 * GridDepth + 1;
  localparam int NumCells    = (1 << (2 * GridDepth)) + 1;
  localparam int CntAddrW    = $clog2(NumCells);
  localparam int BoundW      = 19;                 // 6 * 65535 fits
  localparam int ScaledW     = BoundW + GridDepth + 1;
  localparam logic [CellW-1:0] OutsideCell = CellW'(1 << (2 * GridDepth));
  localparam logic [7:0] OutsideCount = 8'hFB;     // minus five, two's complement

  typedef enum logic [2:0] {
    V_DOMINATED = 3'd0,
    V_DUPLICATE = 3'd1,
    V_APPENDED  = 3'd2,
    V_REPLACED  = 3'd3,
    V_CROWDED   = 3'd4,
    V_FULL      = 3'd5
  } verdict_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DOM_RD, S_DOM_CHK, S_BOUND, S_CLR,
    S_LOC_RD, S_LOC_CNT, S_LOC_INC, S_CAND, S_MRG_RD, S_MRG_CHK, S_APPEND,
    S_CRD_RD, S_CRD_MOST, S_CRD_MRD, S_CRD_CRD, S_CRD_CHK, S_CRD_SEL, S_CRD_INC,
    S_DONE
  } state_t;

endpackage

>>> rtl/pareto_archive_grid_update_unit.sv
// ----------------------------------------------------------------------------
// pareto_archive_grid_update_unit: two-objective Pareto archive, adaptive grid
// Screens a candidate against the archive, refreshes the grid bounds,
// recomputes member cells and counts, then stores, replaces or drops it.
// ----------------------------------------------------------------------------
//  channel   | ports                                       | handshake
//  ----------+---------------------------------------------+----------------
//  candidate | cost_first, cost_second                     | start & !busy
//  result    | verdict, slot, member_count, cell_res       | done, one cycle
//
// An append runs through the dominance and min/max scan, the bound update,
// a sweep of the whole count RAM, cell recompute, merge with in-place
// compaction, store and finish. A replacement or duplicate has no store
// step; a full archive adds a crowding scan; a dominated candidate finishes
// within the dominance scan. The single-port RAMs serialize each step.
// rst clears the control state, occupancy and bounds; the count RAM is swept
// to zero at the start of every refresh, so no clearing pass follows reset.
// The receiver cannot stall: done pulses for one cycle and busy drops with it.
// ----------------------------------------------------------------------------
module pareto_archive_grid_update_unit
  import pag_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [15:0]       cost_first,
  input  logic [15:0]       cost_second,
  output logic              done,
  output logic [2:0]        verdict,
  output logic [5:0]        slot,
  output logic [6:0]        member_count,
  output logic [8:0]        cell_res
);
  state_t state, state_next;

  // candidate and bounds
  logic [15:0]            cand_a, cand_b;
  logic [1:0][BoundW-1:0] low, span;
  logic [15:0]            lo_a, lo_b, hi_a, hi_b;
  logic [CountW-1:0]      occ;       // occupancy
  logic [CountW-1:0]      n;         // members in play this transaction
  logic [CountW-1:0]      idx;       // scan index
  logic [CountW-1:0]      wptr;      // compaction write pointer
  logic [CntAddrW-1:0]    cidx;      // count RAM sweep index
  logic                   joined, found;
  logic [AddrW-1:0]       slot_sel, repl;
  logic [CellW-1:0]       cand_cell, mcell;
  logic signed [8:0]      most;      // crowding threshold
  verdict_t               vd;

  // result registers
  logic [2:0]             verdict_r;
  logic [5:0]             slot_r;
  logic [6:0]             count_r;
  logic [8:0]             cell_r;

  // member RAM: costs and cell side by side
  logic                   m_we;
  logic [AddrW-1:0]       m_addr;
  logic [32+CellW-1:0]    m_wdata, m_rdata;
  logic [15:0]            m_a, m_b;
  logic [CellW-1:0]       m_cell;
  // count RAM
  logic                   c_we;
  logic [CntAddrW-1:0]    c_addr;
  logic [7:0]             c_wdata, c_rdata;

  assign m_a    = m_rdata[15:0];
  assign m_b    = m_rdata[31:16];
  assign m_cell = m_rdata[32 +: CellW];

  pag_ram #(.Width(32 + CellW), .Depth(ArchiveSize)) u_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
  );
  pag_ram #(.Width(8), .Depth(NumCells)) u_cnt (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
  );

  // one locator, shared between candidate and member
  logic [15:0]      loc_a, loc_b;
  logic [CellW-1:0] loc_cell;
  pag_locate u_loc (
    .cost_a(loc_a), .cost_b(loc_b), .low(low), .span(span), .cell_id(loc_cell)
  );

  logic m_beats_c, c_beats_m, m_eq_c;
  assign m_beats_c = m_a <= cand_a && m_b <= cand_b && (m_a < cand_a || m_b < cand_b);
  assign c_beats_m = cand_a <= m_a && cand_b <= m_b && (cand_a < m_a || cand_b < m_b);
  assign m_eq_c    = m_a == cand_a && m_b == cand_b;

  // Keep the member under merge unless the candidate already joined and
  // beats it as well.
  logic keep;
  assign keep = !(c_beats_m && joined);

  logic last;
  assign last = (idx + CountW'(1) >= n);

  // Locate the member during recompute, the candidate everywhere else.
  always_comb begin
    loc_a = cand_a;
    loc_b = cand_b;
    if (state == S_LOC_CNT) begin
      loc_a = m_a;
      loc_b = m_b;
    end
  end

  // Next state and memory controls.
  always_comb begin
    state_next = state;
    m_we    = 1'b0;
    m_addr  = idx[AddrW-1:0];
    m_wdata = {cand_cell, cand_b, cand_a};
    c_we    = 1'b0;
    c_addr  = cidx;
    c_wdata = 8'd0;
    unique case (state)
      S_IDLE:    if (start) state_next = (occ == '0) ? S_BOUND : S_DOM_RD;
      S_DOM_RD:  state_next = S_DOM_CHK;
      S_DOM_CHK: begin
        if (m_beats_c) state_next = S_DONE;
        else if (last) state_next = S_BOUND;
        else state_next = S_DOM_RD;
      end
      S_BOUND:   state_next = S_CLR;
      S_CLR: begin
        // clear the counts, the outside cell takes its fixed count
        c_we    = 1'b1;
        c_wdata = (cidx == OutsideCell) ? OutsideCount : 8'd0;
        if (cidx == OutsideCell) state_next = (n == '0) ? S_CAND : S_LOC_RD;
      end
      S_LOC_RD:  state_next = S_LOC_CNT;
      S_LOC_CNT: begin
        // store the fresh cell and fetch its count
        m_we    = 1'b1;
        m_wdata = {loc_cell, m_b, m_a};
        c_addr  = loc_cell;
        state_next = S_LOC_INC;
      end
      S_LOC_INC: begin
        c_we    = (mcell != OutsideCell);
        c_addr  = mcell;
        c_wdata = c_rdata + 8'd1;
        state_next = last ? S_CAND : S_LOC_RD;
      end
      S_CAND:    state_next = (n == '0) ? S_APPEND : S_MRG_RD;
      S_MRG_RD:  state_next = S_MRG_CHK;
      S_MRG_CHK: begin
        if (m_eq_c) begin
          state_next = S_DONE;
        end else begin
          // write back in place; members beaten after the first are dropped
          if (keep) begin
            m_we   = 1'b1;
            m_addr = wptr[AddrW-1:0];
            if (!c_beats_m) m_wdata = m_rdata;
          end
          if (!last) state_next = S_MRG_RD;
          else if (joined || c_beats_m) state_next = S_DONE;
          else if (n >= CountW'(ArchiveSize)) state_next = S_CRD_RD;
          else state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        m_we   = 1'b1;
        m_addr = n[AddrW-1:0];
        state_next = S_DONE;
      end
      S_CRD_RD: begin
        c_addr = cand_cell;
        state_next = S_CRD_MOST;
      end
      S_CRD_MOST: state_next = S_CRD_MRD;
      S_CRD_MRD:  state_next = S_CRD_CRD;
      S_CRD_CRD: begin
        c_addr = m_cell;
        state_next = S_CRD_CHK;
      end
      S_CRD_CHK: state_next = last ? S_CRD_SEL : S_CRD_MRD;
      S_CRD_SEL: begin
        if (found) begin
          m_we   = 1'b1;
          m_addr = repl;
          c_addr = cand_cell;
          state_next = S_CRD_INC;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CRD_INC: begin
        c_we    = 1'b1;
        c_addr  = cand_cell;
        c_wdata = c_rdata + 8'd1;
        state_next = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      low       <= '0;
      span      <= '0;
      done      <= 1'b0;
      verdict_r <= '0;
      slot_r    <= '0;
      count_r   <= '0;
      cell_r    <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          cand_a <= cost_first;
          cand_b <= cost_second;
          lo_a <= cost_first;  hi_a <= cost_first;
          lo_b <= cost_second; hi_b <= cost_second;
          n <= occ; idx <= '0; cidx <= '0; wptr <= '0;
          joined <= 1'b0; found <= 1'b0;
          slot_sel <= '0; repl <= '0; vd <= V_APPENDED;
        end
        S_DOM_CHK: begin
          if (m_beats_c) begin
            vd <= V_DOMINATED;
            cand_cell <= loc_cell;
          end
          if (m_a < lo_a) lo_a <= m_a;
          if (m_a > hi_a) hi_a <= m_a;
          if (m_b < lo_b) lo_b <= m_b;
          if (m_b > hi_b) hi_b <= m_b;
          idx <= last ? '0 : idx + CountW'(1);
        end
        S_BOUND: if (loc_cell == OutsideCell) begin
          low[0]  <= BoundW'(lo_a) * BoundW'(4);
          low[1]  <= BoundW'(lo_b) * BoundW'(4);
          span[0] <= BoundW'(hi_a) * BoundW'(6) - BoundW'(lo_a) * BoundW'(4);
          span[1] <= BoundW'(hi_b) * BoundW'(6) - BoundW'(lo_b) * BoundW'(4);
        end
        S_CLR: cidx <= (cidx == OutsideCell) ? '0 : cidx + CntAddrW'(1);
        S_LOC_CNT: mcell <= loc_cell;
        S_LOC_INC: idx <= last ? '0 : idx + CountW'(1);
        S_CAND: cand_cell <= loc_cell;
        S_MRG_CHK: begin
          if (m_eq_c) begin
            vd <= V_DUPLICATE;
          end else begin
            if (c_beats_m && !joined) begin
              joined   <= 1'b1;
              slot_sel <= wptr[AddrW-1:0];
              vd       <= V_REPLACED;
            end
            if (keep) wptr <= wptr + CountW'(1);
            if (last) n <= wptr + CountW'(keep);
            idx <= last ? '0 : idx + CountW'(1);
          end
        end
        S_APPEND: begin
          slot_sel <= n[AddrW-1:0];
          n  <= n + CountW'(1);
          vd <= V_APPENDED;
        end
        S_CRD_MOST: most <= $signed({c_rdata[7], c_rdata}) + 9'sd1;
        S_CRD_CHK: begin
          // last member with the greatest count wins
          if ($signed({c_rdata[7], c_rdata}) >= most) begin
            most  <= $signed({c_rdata[7], c_rdata});
            repl  <= idx[AddrW-1:0];
            found <= 1'b1;
          end
          idx <= last ? '0 : idx + CountW'(1);
        end
        S_CRD_SEL: begin
          if (found) begin
            vd       <= V_CROWDED;
            slot_sel <= repl;
          end else begin
            vd <= V_FULL;
          end
        end
        S_DONE: begin
          done      <= 1'b1;
          occ       <= n;
          verdict_r <= vd;
          slot_r    <= slot_sel;
          count_r   <= n;
          cell_r    <= cand_cell;
        end
        default: ;
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign verdict      = verdict_r;
  assign slot         = slot_r;
  assign member_count = count_r;
  assign cell_res     = cell_r;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CountW'(ArchiveSize)) else $error("occupancy overflow");
`endif
endmodule

>>> rtl/pag_ram.sv
// ----------------------------------------------------------------------------
// pag_ram: generic single-port synchronous RAM
// One address a cycle, always read, written on we; read data registered.
// ----------------------------------------------------------------------------
module pag_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/pag_locate.sv
// ----------------------------------------------------------------------------
// pag_locate: grid cell of one cost pair
// Bounds check and interleaved bisection over GridDepth levels.
// ----------------------------------------------------------------------------
module pag_locate
  import pag_pkg::*;
(
  input  logic [15:0]            cost_a,
  input  logic [15:0]            cost_b,
  input  logic [1:0][BoundW-1:0] low,
  input  logic [1:0][BoundW-1:0] span,
  output logic [CellW-1:0]       cell_id
);
  logic [1:0][15:0]        cost;
  logic [1:0][ScaledW-1:0] run;
  logic [1:0][ScaledW-1:0] pos;
  logic [1:0][ScaledW-1:0] half;
  logic [BoundW+1:0]       e5;
  logic                    outside;

  assign cost[0] = cost_a;
  assign cost[1] = cost_b;

  always_comb begin
    outside = 1'b0;
    cell_id = '0;
    run     = '0;
    pos     = '0;
    half    = '0;
    e5      = '0;
    for (int k = 0; k < 2; k++) begin
      e5 = (BoundW+2)'(cost[k]) * (BoundW+2)'(5);
      if (e5 < (BoundW+2)'(low[k]) ||
          e5 > (BoundW+2)'(low[k]) + (BoundW+2)'(span[k])) begin
        outside = 1'b1;
      end
      run[k] = ScaledW'(low[k]) << GridDepth;
      pos[k] = ScaledW'(e5) << GridDepth;
    end
    for (int d = 1; d <= GridDepth; d++) begin
      for (int k = 0; k < 2; k++) begin
        half[k] = (ScaledW'(span[k]) << GridDepth) >> d;
        if (pos[k] < run[k] + half[k]) begin
          cell_id = cell_id + (CellW'(1) << (k + 2 * (d - 1)));
        end else begin
          run[k] = run[k] + half[k];
        end
      end
    end
    if (outside) begin
      cell_id = OutsideCell;
    end
  end
endmodule

>>> dv/pareto_archive_grid_update_unit_tb.sv
// ----------------------------------------------------------------------------
// pareto_archive_grid_update_unit_tb: self-checking bench for the archive unit
// Drives candidate transactions through the start/busy handshake and
// predicts each verdict, slot, occupancy and grid cell with a behavioral
// model of the archive. Each done pulse is checked against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module pareto_archive_grid_update_unit_tb;
  import pag_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The slowest transaction is a full archive with a crowded replacement;
  // allow a wide margin for the whole run.
  localparam int unsigned CycleLimit = 6_000_000;
  localparam int unsigned DrainWait  = 2_000;
  localparam int          NumGrid    = 1 << (2 * GridDepth);

  typedef struct {
    verdict_t    verdict;
    logic [5:0]  slot;
    logic [6:0]  member_count;
    logic [8:0]  cell_res;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] cost_first;
  logic [15:0] cost_second;
  logic        done;
  logic [2:0]  verdict;
  logic [5:0]  slot;
  logic [6:0]  member_count;
  logic [8:0]  cell_res;

  pareto_archive_grid_update_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cost_first   (cost_first),
    .cost_second  (cost_second),
    .done         (done),
    .verdict      (verdict),
    .slot         (slot),
    .member_count (member_count),
    .cell_res     (cell_res)
  );

  // --------------------------------------------------------------------------
  // Archive model state: costs, cells, cell tallies and grid bounds in units
  // of one fifth of a cost LSB.
  // --------------------------------------------------------------------------
  logic [15:0]     arch_first [ArchiveSize];
  logic [15:0]     arch_second[ArchiveSize];
  int              arch_cell  [ArchiveSize];
  int              cell_tally [NumGrid + 1];
  longint unsigned edge_low   [2];
  longint unsigned edge_span  [2];
  int              members;

  outcome_t pending_outcomes[$];
  int       error_count;
  int       send_idle_pct;
  longint unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop for a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("pareto_archive_grid_update_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic bit beats(logic [15:0] a0, logic [15:0] a1,
                               logic [15:0] b0, logic [15:0] b1);
    return (a0 <= b0) && (a1 <= b1) && ((a0 < b0) || (a1 < b1));
  endfunction

  // Interleaved bisection: compare against the running lower edge at each
  // level, first objective in the even bit, second in the odd bit.
  function automatic int grid_cell(logic [15:0] c0, logic [15:0] c1);
    longint unsigned run [2];
    longint unsigned pos [2];
    longint unsigned e;
    longint unsigned half;
    int loc;
    loc = 0;
    for (int k = 0; k < 2; k++) begin
      e = (k == 0) ? longint'(c0) * 5 : longint'(c1) * 5;
      if (e < edge_low[k] || e > edge_low[k] + edge_span[k]) return NumGrid;
      run[k] = edge_low[k] << GridDepth;
      pos[k] = e << GridDepth;
    end
    for (int d = 1; d <= GridDepth; d++) begin
      for (int k = 0; k < 2; k++) begin
        half = (edge_span[k] << GridDepth) >> d;
        if (pos[k] < run[k] + half) loc += 1 << (k + 2 * (d - 1));
        else run[k] += half;
      end
    end
    return loc;
  endfunction

  // Recompute bounds (only when the candidate falls outside the grid) and
  // every member's cell.
  function automatic void regrid(logic [15:0] c0, logic [15:0] c1, int n);
    logic [15:0] lo0, hi0, lo1, hi1;
    lo0 = c0; hi0 = c0; lo1 = c1; hi1 = c1;
    for (int i = 0; i < n; i++) begin
      if (arch_first[i] < lo0) lo0 = arch_first[i];
      if (arch_first[i] > hi0) hi0 = arch_first[i];
      if (arch_second[i] < lo1) lo1 = arch_second[i];
      if (arch_second[i] > hi1) hi1 = arch_second[i];
    end
    if (grid_cell(c0, c1) == NumGrid) begin
      edge_low[0]  = longint'(lo0) * 4;
      edge_span[0] = longint'(hi0) * 6 - edge_low[0];
      edge_low[1]  = longint'(lo1) * 4;
      edge_span[1] = longint'(hi1) * 6 - edge_low[1];
    end
    for (int i = 0; i < NumGrid; i++) cell_tally[i] = 0;
    for (int i = 0; i < n; i++) begin
      arch_cell[i] = grid_cell(arch_first[i], arch_second[i]);
      cell_tally[arch_cell[i]]++;
    end
    cell_tally[NumGrid] = -5;
  endfunction

  function automatic outcome_t archive_update(logic [15:0] c0, logic [15:0] c1);
    outcome_t res;
    int  n, cand_cell, wr, most, repl;
    bit  joined, dup, found;
    bit  doomed[ArchiveSize];
    n = members;
    joined = 0; dup = 0; found = 0; repl = 0;
    res.slot = '0;
    for (int i = 0; i < n; i++) begin
      if (beats(arch_first[i], arch_second[i], c0, c1)) begin
        res.verdict      = V_DOMINATED;
        res.member_count = 7'(n);
        res.cell_res     = 9'(grid_cell(c0, c1));
        return res;
      end
    end
    regrid(c0, c1, n);
    cand_cell = grid_cell(c0, c1);
    res.cell_res = 9'(cand_cell);
    if (n == 0) begin
      arch_first[0] = c0; arch_second[0] = c1; arch_cell[0] = cand_cell;
      n = 1;
      res.verdict = V_APPENDED;
    end else begin
      for (int i = 0; i < n; i++) doomed[i] = 0;
      for (int i = 0; i < n; i++) begin
        if (arch_first[i] == c0 && arch_second[i] == c1) begin
          dup = 1;
          break;
        end
        if (beats(c0, c1, arch_first[i], arch_second[i])) begin
          if (!joined) begin
            arch_first[i] = c0; arch_second[i] = c1; arch_cell[i] = cand_cell;
            res.slot = 6'(i);
            joined = 1;
          end else doomed[i] = 1;
        end
      end
      // Compact out every further member the candidate beats.
      wr = 0;
      for (int i = 0; i < n; i++) begin
        if (!doomed[i]) begin
          arch_first[wr] = arch_first[i];
          arch_second[wr] = arch_second[i];
          arch_cell[wr] = arch_cell[i];
          wr++;
        end
      end
      n = wr;
      if (joined) res.verdict = V_REPLACED;
      else if (dup) res.verdict = V_DUPLICATE;
      else if (n >= ArchiveSize) begin
        most = cell_tally[cand_cell] + 1;
        for (int i = 0; i < n; i++) begin
          if (cell_tally[arch_cell[i]] >= most) begin
            most = cell_tally[arch_cell[i]];
            repl = i;
            found = 1;
          end
        end
        if (found) begin
          arch_first[repl] = c0; arch_second[repl] = c1; arch_cell[repl] = cand_cell;
          cell_tally[cand_cell]++;
          res.slot = 6'(repl);
          res.verdict = V_CROWDED;
        end else res.verdict = V_FULL;
      end else begin
        arch_first[n] = c0; arch_second[n] = c1; arch_cell[n] = cand_cell;
        res.slot = 6'(n);
        n++;
        res.verdict = V_APPENDED;
      end
    end
    members = n;
    res.member_count = 7'(n);
    return res;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Compare every done pulse with the oldest prediction.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = pending_outcomes.pop_front();
        if (verdict !== want.verdict)
          report_mismatch($sformatf("verdict got %0d want %0d", verdict, want.verdict));
        if (slot !== want.slot)
          report_mismatch($sformatf("slot got %0d want %0d", slot, want.slot));
        if (member_count !== want.member_count)
          report_mismatch($sformatf("member_count got %0d want %0d",
                                    member_count, want.member_count));
        if (cell_res !== want.cell_res)
          report_mismatch($sformatf("cell_res got %0d want %0d", cell_res, want.cell_res));
      end
    end
  end

  // Offer one candidate; hold start until the handshake lands, then predict.
  // Start is left high so back-to-back transactions need no toggle.
  task automatic send_candidate(logic [15:0] c0, logic [15:0] c1);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    start = 1'b1;
    cost_first = c0;
    cost_second = c1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_outcomes.push_back(archive_update(c0, c1));
  endtask

  // Drop start and hold until every outstanding result has arrived.
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  // Empty archive, extremes, duplicate, dominated, single and multi-member replacement.
  task automatic test_corner_candidates();
    send_candidate(16'hFFFF, 16'hFFFF);
    send_candidate(16'hFFFF, 16'hFFFF);
    send_candidate(16'h0000, 16'hFFFF);
    send_candidate(16'hFFFF, 16'h0000);
    send_candidate(16'hFFFF, 16'hFFFF);
    send_candidate(16'h8000, 16'h8000);
    send_candidate(16'h8000, 16'h8000);
    send_candidate(16'h8001, 16'h8000);
    send_candidate(16'h4000, 16'h7000);
    send_candidate(16'h7000, 16'h4000);
    // Beat several members at once: one replacement plus compaction.
    send_candidate(16'h3000, 16'h3000);
  endtask

  // Points on x + y = level are mutually non-dominated, so a batch fills the
  // archive and reaches crowded replacement and the full-drop case. A lower
  // level in the next batch sweeps the old front out.
  task automatic test_front_batches(int batches, int per_batch);
    int level, lo_x, hi_x, x, cluster;
    for (int b = 0; b < batches; b++) begin
      level = $urandom_range(1000, 131000);
      lo_x  = (level > 65535) ? level - 65535 : 0;
      hi_x  = (level > 65535) ? 65535 : level;
      cluster = $urandom_range(lo_x, hi_x);
      for (int j = 0; j < per_batch; j++) begin
        if ($urandom_range(99) < 15) begin
          send_candidate(16'($urandom), 16'($urandom));
        end else begin
          // Half cluster near one point so some cells crowd up.
          if ($urandom_range(1)) x = $urandom_range(lo_x, hi_x);
          else x = cluster + $urandom_range(0, 300) - 150;
          if (x < lo_x) x = lo_x;
          if (x > hi_x) x = hi_x;
          send_candidate(16'(x), 16'(level - x));
        end
      end
    end
  endtask

  // Origin beats everything; afterwards it returns as a duplicate and the rest are dominated.
  task automatic test_origin_takeover();
    send_candidate(16'h0000, 16'h0000);
    send_candidate(16'h0000, 16'h0000);
    send_candidate(16'h0001, 16'h0000);
    send_candidate(16'hFFFF, 16'hFFFF);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cost_first = '0;
    cost_second = '0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 27;
    members = 0;
    for (int i = 0; i <= NumGrid; i++) cell_tally[i] = 0;
    for (int k = 0; k < 2; k++) begin
      edge_low[k] = 0;
      edge_span[k] = 0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_corner_candidates();
    test_front_batches(4, 80);
    drain_results();
    send_idle_pct = 59;
    test_front_batches(4, 80);
    drain_results();
    send_idle_pct = 0;
    test_front_batches(4, 75);
    test_origin_takeover();
    drain_results();
    repeat (DrainWait) @(posedge clk);

    if (error_count == 0) begin
      $display("pareto_archive_grid_update_unit_tb: done, clean");
    end else begin
      $display("pareto_archive_grid_update_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
